// ----- sv/grid_rectangle_first_fit_allocator_defines.svh -----
// assertion macros for the allocator checker
`ifndef GRID_RECTANGLE_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define GRID_RECTANGLE_FIRST_FIT_ALLOCATOR_DEFINES_SVH

`define GRFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define GRFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/grfa_pkg.sv -----
`timescale 1ns / 1ps
package grfa_pkg;
    localparam int MaxEntries = 32;
    localparam int MaxDim = 16;
    localparam int SlotW = $clog2(MaxEntries);
    localparam int DimW = $clog2(MaxDim + 1);
    localparam int PosW = $clog2(MaxDim);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_BAD = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_FULL = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_BLOCKED = 3'd5
    } t_status;

    typedef enum logic {
        CFG_GRID_WIDTH = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LOADED,
        S_BOUND,
        S_SCAN,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PosW-1:0] x;
        logic [PosW-1:0] y;
        logic [DimW-1:0] w;
        logic [DimW-1:0] h;
    } t_geom;

    typedef struct packed {
        logic            we;
        logic [SlotW-1:0] waddr;
        t_geom           wdata;
        logic [SlotW-1:0] raddr;
    } t_mem_req;
endpackage

// ----- sv/grid_rectangle_first_fit_allocator.sv -----
`timescale 1ns / 1ps
// path from the accepting edge to the strobe: remove and rejects go straight from S_IDLE to S_DONE
// move runs S_LOAD, S_LOADED and S_BOUND, then the entry scan; add runs S_BOUND, then one scan
// per candidate position (at most 256 positions); S_SCAN per slot, plus S_CMP per stored entry read
// one item at a time; the next beat is accepted at the edge that ends the strobe cycle
// reset: synchronous active low, table empty, grid 8 by 8, geometry memory not cleared
// results are a one-cycle strobe; the receiver cannot stall
module grid_rectangle_first_fit_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [4:0] i_cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [4:0] i_item_width,
    input  logic [4:0] i_item_height,
    input  logic [4:0] i_handle,
    input  logic [3:0] i_pos_x,
    input  logic [3:0] i_pos_y,
    output logic       o_valid,
    output logic       o_ok,
    output logic [2:0] o_status,
    output logic [4:0] o_out_handle,
    output logic [3:0] o_out_x,
    output logic [3:0] o_out_y
);
    import grfa_pkg::*;

    t_state r_state, n_state;
    logic [4:0] r_gw, r_gh;
    logic [MaxEntries-1:0] r_used;
    t_action r_act;
    logic [DimW-1:0] r_w, r_h;
    logic [SlotW-1:0] r_hd, r_slot, r_idx;
    logic [PosW-1:0] r_x, r_y;
    logic [DimW-1:0] r_ew, r_eh;
    logic r_ok;
    t_status r_st;
    logic [SlotW-1:0] r_oh;
    t_mem_req s_req;
    t_geom s_rd;

    logic [DimW-1:0] s_ew, s_eh;
    logic s_free_slot_found;
    logic [SlotW-1:0] s_free_slot;
    t_action s_act;
    t_status s_init_st;
    logic s_accept, s_inb, s_hit, s_stale, s_skip, s_last_entry, s_x_more, s_y_more;

    assign s_ew = (r_gw > 5'(MaxDim)) ? DimW'(MaxDim) : DimW'(r_gw);
    assign s_eh = (r_gh > 5'(MaxDim)) ? DimW'(MaxDim) : DimW'(r_gh);
    assign s_act = t_action'(i_action);
    assign s_accept = start && !busy;
    assign busy = (r_state != S_IDLE);

    always_comb begin
        s_free_slot_found = 1'b0;
        s_free_slot = '0;
        for (int i = MaxEntries - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                s_free_slot_found = 1'b1;
                s_free_slot = SlotW'(i);
            end
        end
    end

    always_comb begin
        s_init_st = ST_OK;
        unique case (s_act) inside
            ACT_ADD: begin
                if ((i_item_width == '0) || (i_item_height == '0)
                    || (i_item_width > s_ew) || (i_item_height > s_eh))
                    s_init_st = ST_BAD_SIZE;
                else if (!s_free_slot_found)
                    s_init_st = ST_FULL;
            end
            ACT_MOVE, ACT_REMOVE: begin
                if (!r_used[i_handle]) s_init_st = ST_UNKNOWN;
            end
            default: s_init_st = ST_UNKNOWN;
        endcase
    end

    grfa_geom_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (s_req),
        .o_rdata(s_rd)
    );

    // candidate in bounds and overlap with current entry
    assign s_inb = (r_w != '0) && (r_h != '0) && (r_w <= r_ew) && (r_h <= r_eh)
        && ((DimW+1)'(r_x) + (DimW+1)'(r_w) <= (DimW+1)'(r_ew))
        && ((DimW+1)'(r_y) + (DimW+1)'(r_h) <= (DimW+1)'(r_eh));
    assign s_stale = !((s_rd.w != '0) && (s_rd.h != '0) && (s_rd.w <= r_ew)
        && (s_rd.h <= r_eh));
    assign s_hit = ((DimW+1)'(r_x) < (DimW+1)'(s_rd.x) + (DimW+1)'(s_rd.w))
        && ((DimW+1)'(r_x) + (DimW+1)'(r_w) > (DimW+1)'(s_rd.x))
        && ((DimW+1)'(r_y) < (DimW+1)'(s_rd.y) + (DimW+1)'(s_rd.h))
        && ((DimW+1)'(r_y) + (DimW+1)'(r_h) > (DimW+1)'(s_rd.y));
    assign s_x_more = ((DimW+1)'(r_x) + (DimW+1)'(r_w) < (DimW+1)'(r_ew));
    assign s_y_more = ((DimW+1)'(r_y) + (DimW+1)'(r_h) < (DimW+1)'(r_eh));
    assign s_last_entry = (r_idx == SlotW'(MaxEntries - 1));
    assign s_skip = !r_used[r_idx] || ((r_act == ACT_MOVE) && (r_idx == r_hd));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if ((s_init_st != ST_OK) || (s_act == ACT_REMOVE)) n_state = S_DONE;
                    else if (s_act == ACT_ADD) n_state = S_BOUND;
                    else n_state = S_LOAD;
                end
            end
            S_LOAD:   n_state = S_LOADED;
            S_LOADED: n_state = S_BOUND;
            S_BOUND:  n_state = s_inb ? S_SCAN : S_DONE;
            S_SCAN: begin
                if (!s_skip) n_state = S_CMP;
                else if (s_last_entry) n_state = S_DONE;
            end
            S_CMP: begin
                if (s_stale) begin
                    n_state = S_DONE;
                end else if (s_hit) begin
                    if ((r_act == ACT_MOVE) || (!s_x_more && !s_y_more)) n_state = S_DONE;
                    else n_state = S_SCAN;
                end else if (s_last_entry) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_req = '0;
        s_req.raddr = (r_state == S_LOAD) ? r_hd : r_idx;
        if ((r_state == S_DONE) && r_ok && (r_act != ACT_REMOVE)) begin
            s_req.we = 1'b1;
            s_req.waddr = (r_act == ACT_ADD) ? r_slot : r_hd;
            s_req.wdata.x = r_x;
            s_req.wdata.y = r_y;
            s_req.wdata.w = r_w;
            s_req.wdata.h = r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gw <= 5'd8;
            r_gh <= 5'd8;
            r_used <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_GRID_HEIGHT) r_gh <= i_cfg_data;
                else r_gw <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_act <= s_act;
                        r_w <= i_item_width;
                        r_h <= i_item_height;
                        r_hd <= i_handle;
                        r_ew <= s_ew;
                        r_eh <= s_eh;
                        r_slot <= s_free_slot;
                        r_st <= s_init_st;
                        r_idx <= '0;
                        r_ok <= (s_init_st == ST_OK) && (s_act == ACT_REMOVE);
                        r_oh <= ((s_act == ACT_MOVE) || (s_act == ACT_REMOVE)) ? i_handle : '0;
                        r_x <= (s_act == ACT_MOVE) ? i_pos_x : '0;
                        r_y <= (s_act == ACT_MOVE) ? i_pos_y : '0;
                        if ((s_init_st == ST_OK) && (s_act == ACT_REMOVE))
                            r_used[i_handle] <= 1'b0;
                    end
                end
                S_LOADED: begin
                    // move takes the stored size
                    r_w <= s_rd.w;
                    r_h <= s_rd.h;
                end
                S_BOUND: begin
                    if (!s_inb) r_st <= ST_BLOCKED;
                end
                S_SCAN: begin
                    if (s_skip) begin
                        if (s_last_entry) r_ok <= 1'b1;
                        else r_idx <= r_idx + 1'b1;
                    end
                end
                S_CMP: begin
                    if (s_stale || (s_hit && ((r_act == ACT_MOVE) || (!s_x_more && !s_y_more)))) begin
                        r_st <= (r_act == ACT_ADD) ? ST_NO_SPACE : ST_BLOCKED;
                    end else if (s_hit) begin
                        // next candidate position: x steps along the row, then y moves to the next row
                        r_idx <= '0;
                        if (s_x_more) begin
                            r_x <= r_x + 1'b1;
                        end else begin
                            r_x <= '0;
                            r_y <= r_y + 1'b1;
                        end
                    end else if (s_last_entry) begin
                        r_ok <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_ok <= r_ok;
                    o_status <= r_st;
                    o_out_handle <= (r_ok && (r_act == ACT_ADD)) ? r_slot : r_oh;
                    o_out_x <= r_ok ? r_x : '0;
                    o_out_y <= r_ok ? r_y : '0;
                    if (r_ok && (r_act == ACT_ADD)) r_used[r_slot] <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- sv/grfa_geom_mem.sv -----
`timescale 1ns / 1ps
module grfa_geom_mem (
    input  logic              i_clk,
    input  grfa_pkg::t_mem_req i_req,
    output grfa_pkg::t_geom   o_rdata
);
    import grfa_pkg::*;
    t_geom r_mem [MaxEntries];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

// ----- sv/grfa_checker.sv -----
`timescale 1ns / 1ps
`include "grid_rectangle_first_fit_allocator_defines.svh"
module grfa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_ok,
    input logic [2:0] o_status,
    input logic [3:0] o_out_x,
    input logic [3:0] o_out_y
);
    import grfa_pkg::*;
    `GRFA_ASSERT_IMPL(a_ok_status, i_clk, i_rst_n, o_valid, o_ok == (o_status == ST_OK))
    `GRFA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && !o_ok, (o_out_x | o_out_y) == '0)
    `GRFA_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `GRFA_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
endmodule

bind grid_rectangle_first_fit_allocator grfa_checker u_grfa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid),
    .o_ok(o_ok), .o_status(o_status), .o_out_x(o_out_x), .o_out_y(o_out_y)
);
